// ===== sv/c2u_pkg.sv =====
`default_nettype none

package c2u_pkg;

   localparam int unsigned ByteWidth  = 8;
   localparam int unsigned PointWidth = 21;
   localparam int unsigned MaxResults = 3;

   localparam logic [7:0] CsrDirection   = 8'd0;
   localparam logic [7:0] CsrReplacement = 8'd1;

   localparam logic DirEncode = 1'b0;
   localparam logic DirDecode = 1'b1;

   localparam logic [7:0] ReplacementReset = 8'd63;

   typedef logic [ByteWidth-1:0]  byte_type;
   typedef logic [PointWidth-1:0] point_type;

   // Bytes of one input's results; entry 0 goes out first.
   typedef struct packed {
      logic [MaxResults-1:0][ByteWidth-1:0] bytes;
      logic [1:0]                            count;
   } result_type;

   // Windows-1252 byte to its Unicode code point.
   function automatic logic [15:0] c2u_byte_to_point(input byte_type b);
      logic [15:0] cp;
      begin
         unique case (b)
            8'd128:  cp = 16'd8364;
            8'd130:  cp = 16'd8218;
            8'd131:  cp = 16'd402;
            8'd132:  cp = 16'd8222;
            8'd133:  cp = 16'd8230;
            8'd134:  cp = 16'd8224;
            8'd135:  cp = 16'd8225;
            8'd136:  cp = 16'd710;
            8'd137:  cp = 16'd8240;
            8'd138:  cp = 16'd352;
            8'd139:  cp = 16'd8249;
            8'd140:  cp = 16'd338;
            8'd142:  cp = 16'd381;
            8'd145:  cp = 16'd8216;
            8'd146:  cp = 16'd8217;
            8'd147:  cp = 16'd8220;
            8'd148:  cp = 16'd8221;
            8'd149:  cp = 16'd8226;
            8'd150:  cp = 16'd8211;
            8'd151:  cp = 16'd8212;
            8'd152:  cp = 16'd732;
            8'd153:  cp = 16'd8482;
            8'd154:  cp = 16'd353;
            8'd155:  cp = 16'd8250;
            8'd156:  cp = 16'd339;
            8'd158:  cp = 16'd382;
            8'd159:  cp = 16'd376;
            default: cp = {8'd0, b};
         endcase
         return cp;
      end
   endfunction

   // Completed code point back to a Windows-1252 byte.
   function automatic byte_type c2u_point_to_byte(input point_type cp, input byte_type repl);
      byte_type b;
      begin
         if (cp <= 21'd127 || cp == 21'd129 || (cp >= 21'd160 && cp <= 21'd255)) begin
            b = cp[7:0];
         end else begin
            unique case (cp)
               21'd8364: b = 8'd128;
               21'd8218: b = 8'd130;
               21'd402:  b = 8'd131;
               21'd8222: b = 8'd132;
               21'd8230: b = 8'd133;
               21'd8224: b = 8'd134;
               21'd8225: b = 8'd135;
               21'd710:  b = 8'd136;
               21'd8240: b = 8'd137;
               21'd352:  b = 8'd138;
               21'd8249: b = 8'd139;
               21'd338:  b = 8'd140;
               21'd381:  b = 8'd142;
               21'd8216: b = 8'd145;
               21'd8217: b = 8'd146;
               21'd8220: b = 8'd147;
               21'd8221: b = 8'd148;
               21'd8226: b = 8'd149;
               21'd8211: b = 8'd150;
               21'd8212: b = 8'd151;
               21'd732:  b = 8'd152;
               21'd8482: b = 8'd153;
               21'd353:  b = 8'd154;
               21'd8250: b = 8'd155;
               21'd339:  b = 8'd156;
               21'd382:  b = 8'd158;
               21'd376:  b = 8'd159;
               default:  b = repl;
            endcase
         end
         return b;
      end
   endfunction

endpackage

`default_nettype wire

// ===== sv/cp1252_utf8_transcoder.sv =====
// Windows-1252 / UTF-8 byte-stream transcoder.
// Input channel (req_): one source byte per beat, req_in_last on the final
// byte of a text. Result channel (rsp_): one converted byte per beat,
// rsp_out_last on the final result byte caused by an input beat.
// Configuration (csr_): index 0 selects direction (0 encodes Windows-1252 to
// UTF-8, 1 decodes UTF-8 to Windows-1252), index 1 sets the replacement byte.
// csr_ready is always high; other indexes are ignored. Write only while idle.
// An accepted beat sits in the input register until the result buffer is
// free, is then transcoded into a three-byte result buffer, and its first
// result is offered from that buffer. The output side moves one byte per
// cycle while rsp_ready is high; an input beat gives 1 to 3 result bytes
// when encoding and at most one when decoding (a decode beat may give no
// result at all). The result buffer drain sets the sustained rate.
// A new input beat is taken while the previous results wait to be taken.
// When the receiver stalls, the buffer and then the input register fill and
// req_ready drops. Reset clears both registers, the partial UTF-8 sequence,
// and returns the registers to encode direction and '?' as replacement.
`default_nettype none

module cp1252_utf8_transcoder (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire c2u_pkg::byte_type req_in_byte,
   input  wire logic              req_in_last,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output c2u_pkg::byte_type      rsp_out_byte,
   output logic                   rsp_out_last,
   input  wire logic              csr_valid,
   output logic                   csr_ready,
   input  wire logic [7:0]        csr_index,
   input  wire logic [7:0]        csr_data
);
   import c2u_pkg::*;

   logic       dir_ff;
   byte_type   repl_ff;

   logic       in_valid_ff;
   logic       in_valid_in;
   byte_type   in_byte_ff;
   logic       in_last_ff;

   point_type  part_ff;
   point_type  part_in;
   logic [1:0] rem_ff;
   logic [1:0] rem_in;

   logic [MaxResults-1:0][ByteWidth-1:0] buf_ff;
   logic [1:0]                            cnt_ff;

   result_type res;
   logic       buf_free;
   logic       load;
   logic       pop;
   logic [15:0] enc_cp;
   point_type  dec_cp;

   assign csr_ready    = 1'b1;
   assign rsp_valid    = (cnt_ff != 2'd0);
   assign rsp_out_byte = buf_ff[0];
   assign rsp_out_last = (cnt_ff == 2'd1);
   assign pop          = rsp_valid && rsp_ready;
   assign buf_free     = (cnt_ff == 2'd0) || ((cnt_ff == 2'd1) && rsp_ready);
   assign load         = in_valid_ff && buf_free;
   assign req_ready    = !in_valid_ff || buf_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         dir_ff  <= DirEncode;
         repl_ff <= ReplacementReset;
      end else if (csr_valid && csr_ready) begin
         if (csr_index == CsrDirection) begin
            dir_ff <= csr_data[0];
         end else if (csr_index == CsrReplacement) begin
            repl_ff <= csr_data;
         end
      end
   end

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
      end else if (load) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      if (req_valid && req_ready) begin
         in_byte_ff <= req_in_byte;
         in_last_ff <= req_in_last;
      end
   end

   // Transcode the held beat against the current decode state.
   always_comb begin
      res     = '0;
      part_in = part_ff;
      rem_in  = rem_ff;
      enc_cp  = c2u_byte_to_point(in_byte_ff);
      dec_cp  = {part_ff[PointWidth-7:0], in_byte_ff[5:0]};
      if (dir_ff == DirEncode) begin
         if (enc_cp < 16'h0080) begin
            res.bytes[0] = enc_cp[7:0];
            res.count    = 2'd1;
         end else if (enc_cp < 16'h0800) begin
            res.bytes[0] = {3'b110, enc_cp[10:6]};
            res.bytes[1] = {2'b10, enc_cp[5:0]};
            res.count    = 2'd2;
         end else begin
            res.bytes[0] = {4'b1110, enc_cp[15:12]};
            res.bytes[1] = {2'b10, enc_cp[11:6]};
            res.bytes[2] = {2'b10, enc_cp[5:0]};
            res.count    = 2'd3;
         end
      end else begin
         priority if (in_byte_ff[7] == 1'b0) begin
            rem_in       = 2'd0;
            part_in      = '0;
            res.bytes[0] = in_byte_ff;
            res.count    = 2'd1;
         end else if (in_byte_ff[7:6] == 2'b10) begin
            if (rem_ff == 2'd0) begin
               res.bytes[0] = repl_ff;
               res.count    = 2'd1;
            end else if (rem_ff == 2'd1) begin
               // Final continuation byte completes the code point.
               rem_in       = 2'd0;
               part_in      = '0;
               res.bytes[0] = c2u_point_to_byte(dec_cp, repl_ff);
               res.count    = 2'd1;
            end else begin
               rem_in  = rem_ff - 2'd1;
               part_in = dec_cp;
            end
         end else if (in_byte_ff[7:5] == 3'b110) begin
            part_in = {16'd0, in_byte_ff[4:0]};
            rem_in  = 2'd1;
         end else if (in_byte_ff[7:4] == 4'b1110) begin
            part_in = {17'd0, in_byte_ff[3:0]};
            rem_in  = 2'd2;
         end else if (in_byte_ff[7:3] == 5'b11110) begin
            part_in = {18'd0, in_byte_ff[2:0]};
            rem_in  = 2'd3;
         end else begin
            part_in      = '0;
            rem_in       = 2'd0;
            res.bytes[0] = repl_ff;
            res.count    = 2'd1;
         end
      end
      if (in_last_ff) begin
         part_in = '0;
         rem_in  = 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         part_ff <= '0;
         rem_ff  <= 2'd0;
      end else if (load) begin
         part_ff <= part_in;
         rem_ff  <= rem_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
      end else if (load) begin
         cnt_ff <= res.count;
      end else if (pop) begin
         cnt_ff <= cnt_ff - 2'd1;
      end
      if (load) begin
         buf_ff <= res.bytes;
      end else if (pop) begin
         buf_ff[0] <= buf_ff[1];
         buf_ff[1] <= buf_ff[2];
      end
   end

   a_encode_gives_result: assert property (@(posedge clock) disable iff (reset)
      load && (dir_ff == DirEncode) |=> cnt_ff != 2'd0)
      else $error("encode beat produced no result bytes");

   a_decode_at_most_one: assert property (@(posedge clock) disable iff (reset)
      load && (dir_ff == DirDecode) |=> cnt_ff == 2'd0 || cnt_ff == 2'd1)
      else $error("decode beat produced more than one byte");

   a_last_clears_state: assert property (@(posedge clock) disable iff (reset)
      load && in_last_ff |=> rem_ff == 2'd0 && part_ff == '0)
      else $error("decode state survived a last beat");

   a_stall_holds_input: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !load |=> in_valid_ff && $stable(in_byte_ff))
      else $error("held input beat lost while the buffer was busy");

endmodule

`default_nettype wire
